// File: sv/bcq_pkg.sv
// Shared types, codes and width helpers for the broadcast event queue block.
package bcq_pkg;

	localparam int NUM_QUEUES_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int HANDLE_W = 16;
	localparam int TIME_W   = 32;
	localparam int REC_W    = TIME_W + 1;

	localparam logic [HANDLE_W-1:0] HANDLE_MAX = '1;

	// Function codes of a request.
	localparam logic [2:0] FN_EVENT = 3'd0;
	localparam logic [2:0] FN_OPEN  = 3'd1;
	localparam logic [2:0] FN_FLUSH = 3'd2;
	localparam logic [2:0] FN_CLOSE = 3'd3;
	localparam logic [2:0] FN_READ  = 3'd4;

	// Status codes of a response.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOQUEUE = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_NOSLOT  = 2'd3;

	typedef struct packed {
		logic [2:0]          func;
		logic [HANDLE_W-1:0] queue_handle;
		logic [TIME_W-1:0]   event_time;
		logic                edge_level;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] new_handle;
		logic [TIME_W-1:0]   read_time;
		logic                read_level;
	} rsp_t;

	// Commands to the slot table.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic set_vld;
		logic clr_vld;
	} slot_ctl_t;

	// Commands to the record store.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} rec_ctl_t;

	function automatic int slot_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic int ptr_w(input int d);
		return $clog2(d);
	endfunction

	function automatic int cnt_w(input int d);
		return $clog2(d + 1);
	endfunction

endpackage

// File: sv/broadcast_event_queues.sv
// Top level of the broadcast event queues: subscriber FIFOs of time-stamped edge records.
//
// Requests arrive on the req channel (req_valid, req_stall, req) and each one produces
// exactly one response transaction on the rsp channel (rsp_valid, rsp_stall, rsp).
// A transaction moves at a rising edge where valid is high and stall is low.
// Function codes: event append, open, flush, close and read head, as in bcq_pkg.
//
// Every request walks the slot table, one slot per cycle, for every function code; an
// event append writes each open queue's record on the way. The scan is followed by the
// tail, act and done states; the done state loads the response into the output register
// once it is free and returns to idle, where the next request can be taken.
// The block takes one request at a time: req_stall is high from acceptance until the
// response has been loaded into the output register.
//
// The response waits in an output register, so a new request is accepted while the
// previous response is still stalled. If the receiver still stalls when the next
// response is ready, the sequencer holds that response until the register frees up.
//
// Reset closes every queue and clears the handle counter; the record memory needs no
// clearing, since only records that were written can ever be popped.
module broadcast_event_queues #(
	parameter int NUM_QUEUES  = bcq_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = bcq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bcq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bcq_pkg::rsp_t rsp
);
	import bcq_pkg::*;

	localparam int SLOT_W = slot_w(NUM_QUEUES);
	localparam int PTR_W  = ptr_w(QUEUE_DEPTH);
	localparam int CNT_W  = cnt_w(QUEUE_DEPTH);

	slot_ctl_t           slot_ctl;
	logic [SLOT_W-1:0]   slot_rd_addr;
	logic [SLOT_W-1:0]   slot_wr_addr;
	logic [HANDLE_W-1:0] slot_wr_handle;
	logic [CNT_W-1:0]    slot_wr_cnt;
	logic [PTR_W-1:0]    slot_wr_head;
	logic                slot_rd_vld;
	logic [HANDLE_W-1:0] slot_rd_handle;
	logic [CNT_W-1:0]    slot_rd_cnt;
	logic [PTR_W-1:0]    slot_rd_head;
	rec_ctl_t            rec_ctl;
	logic [SLOT_W-1:0]   rec_slot;
	logic [PTR_W-1:0]    rec_ptr;
	logic [REC_W-1:0]    rec_wdata;
	logic [REC_W-1:0]    rec_rdata;

	// The sequencer owns the handshakes and issues every memory access.
	bcq_ctrl #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.slot_ctl       (slot_ctl),
		.slot_rd_addr   (slot_rd_addr),
		.slot_wr_addr   (slot_wr_addr),
		.slot_wr_handle (slot_wr_handle),
		.slot_wr_cnt    (slot_wr_cnt),
		.slot_wr_head   (slot_wr_head),
		.slot_rd_vld    (slot_rd_vld),
		.slot_rd_handle (slot_rd_handle),
		.slot_rd_cnt    (slot_rd_cnt),
		.slot_rd_head   (slot_rd_head),
		.rec_ctl        (rec_ctl),
		.rec_slot       (rec_slot),
		.rec_ptr        (rec_ptr),
		.rec_wdata      (rec_wdata),
		.rec_rdata      (rec_rdata)
	);

	// Per-slot open flag, handle, fill count and head pointer.
	bcq_slot_table #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_slot_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (slot_ctl),
		.rd_addr   (slot_rd_addr),
		.wr_addr   (slot_wr_addr),
		.wr_handle (slot_wr_handle),
		.wr_cnt    (slot_wr_cnt),
		.wr_head   (slot_wr_head),
		.rd_vld    (slot_rd_vld),
		.rd_handle (slot_rd_handle),
		.rd_cnt    (slot_rd_cnt),
		.rd_head   (slot_rd_head)
	);

	// Ring buffers of {level, time} records, one block per slot.
	bcq_record_store #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_record_store (
		.clk   (clk),
		.ctl   (rec_ctl),
		.slot  (rec_slot),
		.ptr   (rec_ptr),
		.wdata (rec_wdata),
		.rdata (rec_rdata)
	);

	// An accepted request blocks the input until its response is produced.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request channel open right after an accepted transaction");

	// The record store is single ported: the pop never overlaps an append write.
	a_rec_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(rec_ctl.rd_en && rec_ctl.wr_en))
		else $error("record store read and written in the same cycle");

	// During the scan the write-back trails the read by one slot.
	a_slot_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_ctl.rd_en && slot_ctl.wr_en) |-> (slot_rd_addr != slot_wr_addr))
		else $error("slot table read and write hit the same entry");

	// A failed request carries no handle and no record.
	a_fail_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_OK) |->
			(rsp.new_handle == '0 && rsp.read_time == '0 && !rsp.read_level))
		else $error("failed response carries payload");

endmodule

// File: sv/bcq_slot_table.sv
// Slot table: open flags in flip-flops and per-slot handle, count and head in a memory.
module bcq_slot_table #(
	parameter int NUM_QUEUES  = bcq_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = bcq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  bcq_pkg::slot_ctl_t                           ctl,
	input  logic [bcq_pkg::slot_w(NUM_QUEUES)-1:0]       rd_addr,
	input  logic [bcq_pkg::slot_w(NUM_QUEUES)-1:0]       wr_addr,
	input  logic [bcq_pkg::HANDLE_W-1:0]                 wr_handle,
	input  logic [bcq_pkg::cnt_w(QUEUE_DEPTH)-1:0]       wr_cnt,
	input  logic [bcq_pkg::ptr_w(QUEUE_DEPTH)-1:0]       wr_head,
	output logic                                         rd_vld,
	output logic [bcq_pkg::HANDLE_W-1:0]                 rd_handle,
	output logic [bcq_pkg::cnt_w(QUEUE_DEPTH)-1:0]       rd_cnt,
	output logic [bcq_pkg::ptr_w(QUEUE_DEPTH)-1:0]       rd_head
);
	import bcq_pkg::*;

	localparam int CNT_W  = cnt_w(QUEUE_DEPTH);
	localparam int PTR_W  = ptr_w(QUEUE_DEPTH);
	localparam int META_W = HANDLE_W + CNT_W + PTR_W;

	logic [NUM_QUEUES-1:0] vld_q;
	logic                  rd_vld_q;
	logic [META_W-1:0]     meta_mem [NUM_QUEUES];
	logic [META_W-1:0]     rd_data_q;

	// Open flags are cleared at reset; the metadata of a slot is written by open.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.set_vld)
				vld_q[wr_addr] <= 1'b1;
			if (ctl.clr_vld)
				vld_q[wr_addr] <= 1'b0;
			if (ctl.rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en)
			meta_mem[wr_addr] <= {wr_handle, wr_cnt, wr_head};
		if (ctl.rd_en)
			rd_data_q <= meta_mem[rd_addr];
	end

	assign rd_vld    = rd_vld_q;
	assign rd_handle = rd_data_q[META_W-1 -: HANDLE_W];
	assign rd_cnt    = rd_data_q[PTR_W +: CNT_W];
	assign rd_head   = rd_data_q[PTR_W-1:0];

endmodule

// File: sv/bcq_record_store.sv
// Record store: one ring of edge records per slot in a single-port memory.
module bcq_record_store #(
	parameter int NUM_QUEUES  = bcq_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = bcq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  bcq_pkg::rec_ctl_t                      ctl,
	input  logic [bcq_pkg::slot_w(NUM_QUEUES)-1:0] slot,
	input  logic [bcq_pkg::ptr_w(QUEUE_DEPTH)-1:0] ptr,
	input  logic [bcq_pkg::REC_W-1:0]              wdata,
	output logic [bcq_pkg::REC_W-1:0]              rdata
);
	import bcq_pkg::*;

	localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(QUEUE_DEPTH);

	logic [REC_W-1:0]  rec_mem [ENTRIES];
	logic [REC_W-1:0]  rd_data_q;
	logic [ADDR_W-1:0] addr;

	// Each slot owns a contiguous block of QUEUE_DEPTH entries.
	assign addr = ADDR_W'(slot) * DEPTH_A + ADDR_W'(ptr);

	always_ff @(posedge clk) begin
		if (ctl.wr_en)
			rec_mem[addr] <= wdata;
		if (ctl.rd_en)
			rd_data_q <= rec_mem[addr];
	end

	assign rdata = rd_data_q;

endmodule

// File: sv/bcq_ctrl.sv
// Sequencer: scans the slot table per request, updates queues and builds the response.
module bcq_ctrl #(
	parameter int NUM_QUEUES  = bcq_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = bcq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_stall,
	input  bcq_pkg::req_t                          req,
	output logic                                   rsp_valid,
	input  logic                                   rsp_stall,
	output bcq_pkg::rsp_t                          rsp,
	output bcq_pkg::slot_ctl_t                     slot_ctl,
	output logic [bcq_pkg::slot_w(NUM_QUEUES)-1:0] slot_rd_addr,
	output logic [bcq_pkg::slot_w(NUM_QUEUES)-1:0] slot_wr_addr,
	output logic [bcq_pkg::HANDLE_W-1:0]           slot_wr_handle,
	output logic [bcq_pkg::cnt_w(QUEUE_DEPTH)-1:0] slot_wr_cnt,
	output logic [bcq_pkg::ptr_w(QUEUE_DEPTH)-1:0] slot_wr_head,
	input  logic                                   slot_rd_vld,
	input  logic [bcq_pkg::HANDLE_W-1:0]           slot_rd_handle,
	input  logic [bcq_pkg::cnt_w(QUEUE_DEPTH)-1:0] slot_rd_cnt,
	input  logic [bcq_pkg::ptr_w(QUEUE_DEPTH)-1:0] slot_rd_head,
	output bcq_pkg::rec_ctl_t                      rec_ctl,
	output logic [bcq_pkg::slot_w(NUM_QUEUES)-1:0] rec_slot,
	output logic [bcq_pkg::ptr_w(QUEUE_DEPTH)-1:0] rec_ptr,
	output logic [bcq_pkg::REC_W-1:0]              rec_wdata,
	input  logic [bcq_pkg::REC_W-1:0]              rec_rdata
);
	import bcq_pkg::*;

	localparam int SLOT_W = slot_w(NUM_QUEUES);
	localparam int PTR_W  = ptr_w(QUEUE_DEPTH);
	localparam int CNT_W  = cnt_w(QUEUE_DEPTH);
	localparam int SUM_W  = PTR_W + 1;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_QUEUES - 1);
	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(QUEUE_DEPTH);
	localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_ACT,
		S_DONE
	} state_t;

	state_t              state_q;
	req_t                req_q;
	logic [SLOT_W-1:0]   scan_q;
	logic                iss_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic                match_found_q;
	logic [SLOT_W-1:0]   match_slot_q;
	logic [CNT_W-1:0]    match_cnt_q;
	logic [PTR_W-1:0]    match_head_q;
	logic                free_found_q;
	logic [SLOT_W-1:0]   free_slot_q;
	logic [HANDLE_W-1:0] hcnt_q;
	logic [1:0]          status_q;
	logic [HANDLE_W-1:0] nh_q;
	logic                rd_ok_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic                ev_we;
	logic                ev_full;
	logic [SUM_W-1:0]    ev_sum;
	logic [PTR_W-1:0]    ev_tail;
	logic [PTR_W-1:0]    ev_head;
	logic [CNT_W-1:0]    ev_cnt;
	logic                s1_match;
	logic                s1_free;
	logic [HANDLE_W-1:0] hnext;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	// Append arithmetic for the slot whose metadata arrives this cycle.
	always_comb begin
		ev_we    = iss_s1 && slot_rd_vld && (req_q.func == FN_EVENT);
		ev_full  = (slot_rd_cnt == DEPTH_C);
		ev_sum   = SUM_W'(slot_rd_head) + SUM_W'(slot_rd_cnt);
		if (ev_full)
			ev_tail = slot_rd_head;
		else if (ev_sum >= DEPTH_S)
			ev_tail = PTR_W'(ev_sum - DEPTH_S);
		else
			ev_tail = PTR_W'(ev_sum);
		ev_head  = ev_full ? ptr_inc(slot_rd_head) : slot_rd_head;
		ev_cnt   = ev_full ? slot_rd_cnt : slot_rd_cnt + CNT_W'(1);
		s1_match = iss_s1 && slot_rd_vld && (slot_rd_handle == req_q.queue_handle);
		s1_free  = iss_s1 && !slot_rd_vld;
		hnext    = (hcnt_q == HANDLE_MAX) ? hcnt_q : hcnt_q + HANDLE_W'(1);
	end

	always_comb begin
		slot_ctl       = '0;
		slot_rd_addr   = scan_q;
		slot_wr_addr   = slot_s1;
		slot_wr_handle = slot_rd_handle;
		slot_wr_cnt    = ev_cnt;
		slot_wr_head   = ev_head;
		rec_ctl        = '0;
		rec_slot       = slot_s1;
		rec_ptr        = ev_tail;
		rec_wdata      = {req_q.edge_level, req_q.event_time};

		if (state_q == S_SCAN)
			slot_ctl.rd_en = 1'b1;
		if (ev_we) begin
			slot_ctl.wr_en = 1'b1;
			rec_ctl.wr_en  = 1'b1;
		end

		if (state_q == S_ACT) begin
			case (req_q.func)
				FN_OPEN: begin
					if (free_found_q) begin
						slot_ctl.wr_en  = 1'b1;
						slot_ctl.set_vld = 1'b1;
						slot_wr_addr    = free_slot_q;
						slot_wr_handle  = hnext;
						slot_wr_cnt     = '0;
						slot_wr_head    = '0;
					end
				end
				FN_FLUSH: begin
					if (match_found_q) begin
						slot_ctl.wr_en = 1'b1;
						slot_wr_addr   = match_slot_q;
						slot_wr_handle = req_q.queue_handle;
						slot_wr_cnt    = '0;
						slot_wr_head   = '0;
					end
				end
				FN_CLOSE: begin
					if (match_found_q) begin
						slot_ctl.clr_vld = 1'b1;
						slot_wr_addr     = match_slot_q;
					end
				end
				FN_READ: begin
					if (match_found_q && match_cnt_q != '0) begin
						slot_ctl.wr_en = 1'b1;
						slot_wr_addr   = match_slot_q;
						slot_wr_handle = req_q.queue_handle;
						slot_wr_cnt    = match_cnt_q - CNT_W'(1);
						slot_wr_head   = ptr_inc(match_head_q);
						rec_ctl.rd_en  = 1'b1;
						rec_slot       = match_slot_q;
						rec_ptr        = match_head_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			req_q         <= '0;
			scan_q        <= '0;
			iss_s1        <= 1'b0;
			slot_s1       <= '0;
			match_found_q <= 1'b0;
			match_slot_q  <= '0;
			match_cnt_q   <= '0;
			match_head_q  <= '0;
			free_found_q  <= 1'b0;
			free_slot_q   <= '0;
			hcnt_q        <= '0;
			status_q      <= ST_OK;
			nh_q          <= '0;
			rd_ok_q       <= 1'b0;
			rsp_q         <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			iss_s1  <= (state_q == S_SCAN);
			slot_s1 <= scan_q;

			// In the done state the load below decides the output valid on its own.
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE)
				rsp_valid_q <= 1'b0;

			// The first matching and the first free slot in scan order win.
			if (s1_match && !match_found_q) begin
				match_found_q <= 1'b1;
				match_slot_q  <= slot_s1;
				match_cnt_q   <= slot_rd_cnt;
				match_head_q  <= slot_rd_head;
			end
			if (s1_free && !free_found_q) begin
				free_found_q <= 1'b1;
				free_slot_q  <= slot_s1;
			end

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q         <= req;
						scan_q        <= '0;
						match_found_q <= 1'b0;
						free_found_q  <= 1'b0;
						status_q      <= ST_OK;
						nh_q          <= '0;
						rd_ok_q       <= 1'b0;
						state_q       <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_q == SLOT_LAST)
						state_q <= S_TAIL;
					else
						scan_q <= scan_q + SLOT_W'(1);
				end
				S_TAIL: begin
					state_q <= S_ACT;
				end
				S_ACT: begin
					case (req_q.func)
						FN_OPEN: begin
							if (free_found_q) begin
								hcnt_q <= hnext;
								nh_q   <= hnext;
							end else begin
								status_q <= ST_NOSLOT;
							end
						end
						FN_FLUSH, FN_CLOSE: begin
							if (!match_found_q)
								status_q <= ST_NOQUEUE;
						end
						FN_READ: begin
							if (!match_found_q)
								status_q <= ST_NOQUEUE;
							else if (match_cnt_q == '0)
								status_q <= ST_EMPTY;
							else
								rd_ok_q <= 1'b1;
						end
						default: begin
						end
					endcase
					state_q <= S_DONE;
				end
				S_DONE: begin
					// The record read issued in the previous state is held in the store.
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status     <= status_q;
						rsp_q.new_handle <= nh_q;
						rsp_q.read_time  <= rd_ok_q ? rec_rdata[TIME_W-1:0] : '0;
						rsp_q.read_level <= rd_ok_q ? rec_rdata[TIME_W] : 1'b0;
						rsp_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: dv/tb_broadcast_event_queues.sv
// Self-checking testbench for the broadcast event queue block.
`timescale 1ns / 1ps

// Mirror of the queue table. It applies each accepted request to its own copy of
// the slots and records, queues the response that request must produce, and
// checks the responses in order as they arrive.
class queue_table_board;
	localparam int NQ = bcq_pkg::NUM_QUEUES_DEF;
	localparam int QD = bcq_pkg::QUEUE_DEPTH_DEF;

	bit                             slot_open [NQ];
	logic [bcq_pkg::HANDLE_W-1:0]   slot_id   [NQ];
	int                             fill      [NQ];
	int                             head      [NQ];
	logic [bcq_pkg::REC_W-1:0]      store     [NQ][QD];
	logic [bcq_pkg::HANDLE_W-1:0]   last_handle;
	bcq_pkg::rsp_t                  due_responses [$];
	int                             errors;

	function new();
		foreach (slot_id[q]) slot_id[q] = '0;
		last_handle = '0;
		errors = 0;
	endfunction

	function void flag(string what, string want, string got);
		errors++;
		$display("%0t: %s expected %s, got %s", $time, what, want, got);
	endfunction

	function void note_request(bcq_pkg::req_t r);
		bcq_pkg::rsp_t e;
		int q;
		int hit;
		int tail;
		e = '0;
		hit = -1;
		case (r.func)
			bcq_pkg::FN_EVENT: begin
				for (q = 0; q < NQ; q++) begin
					if (slot_open[q]) begin
						// A full queue gives up its oldest record first.
						if (fill[q] == QD) begin
							head[q] = (head[q] + 1) % QD;
							fill[q]--;
						end
						tail = (head[q] + fill[q]) % QD;
						store[q][tail] = {r.edge_level, r.event_time};
						fill[q]++;
					end
				end
			end
			bcq_pkg::FN_OPEN: begin
				for (q = NQ - 1; q >= 0; q--)
					if (!slot_open[q]) hit = q;
				if (hit < 0) begin
					e.status = bcq_pkg::ST_NOSLOT;
				end else begin
					if (last_handle != bcq_pkg::HANDLE_MAX) last_handle++;
					slot_open[hit] = 1'b1;
					slot_id[hit]   = last_handle;
					fill[hit]      = 0;
					head[hit]      = 0;
					e.new_handle   = last_handle;
				end
			end
			bcq_pkg::FN_FLUSH, bcq_pkg::FN_CLOSE, bcq_pkg::FN_READ: begin
				// Duplicate handles resolve to the lowest matching slot.
				for (q = NQ - 1; q >= 0; q--)
					if (slot_open[q] && slot_id[q] == r.queue_handle) hit = q;
				if (hit < 0) begin
					e.status = bcq_pkg::ST_NOQUEUE;
				end else if (r.func == bcq_pkg::FN_FLUSH) begin
					fill[hit] = 0;
					head[hit] = 0;
				end else if (r.func == bcq_pkg::FN_CLOSE) begin
					slot_open[hit] = 1'b0;
					slot_id[hit]   = '0;
					fill[hit]      = 0;
					head[hit]      = 0;
				end else if (fill[hit] == 0) begin
					e.status = bcq_pkg::ST_EMPTY;
				end else begin
					{e.read_level, e.read_time} = store[hit][head[hit]];
					head[hit] = (head[hit] + 1) % QD;
					fill[hit]--;
				end
			end
			default: ;
		endcase
		due_responses.push_back(e);
	endfunction

	function void check_response(bcq_pkg::rsp_t got);
		bcq_pkg::rsp_t want;
		if (due_responses.size() == 0) begin
			flag("response", "none", $sformatf("%h", got));
			return;
		end
		want = due_responses.pop_front();
		if (got.status !== want.status)
			flag("status", $sformatf("%0d", want.status), $sformatf("%0d", got.status));
		if (got.new_handle !== want.new_handle)
			flag("new_handle", $sformatf("%h", want.new_handle),
				$sformatf("%h", got.new_handle));
		if (got.read_time !== want.read_time)
			flag("read_time", $sformatf("%h", want.read_time),
				$sformatf("%h", got.read_time));
		if (got.read_level !== want.read_level)
			flag("read_level", $sformatf("%b", want.read_level),
				$sformatf("%b", got.read_level));
	endfunction
endclass

module tb_broadcast_event_queues;
	import bcq_pkg::*;

	localparam int NQ = NUM_QUEUES_DEF;

	// Function codes five to seven are spare: the block answers them with a plain ok.
	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;

	// Slack after the last response, in which stray responses would show up.
	localparam int SETTLE_CYCLES = 30;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// When set, neither side inserts idle cycles.
	bit steady = 1'b0;
	int stall_left = 0;

	queue_table_board board;

	broadcast_event_queues #(
		.NUM_QUEUES (NUM_QUEUES_DEF),
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// About 700 transactions with the longest idle and stall stretches need well
	// under a millisecond of simulated time; this bound is far above that.
	initial begin
		#100_000_000;
		$display("broadcast_event_queues: mismatch");
		$finish;
	end

	// Idle lengths: mostly none, often a few cycles, now and then a long stretch.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady) return 0;
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Response side. Everything is sampled at the rising edge, before this edge's
	// nonblocking updates land, so a transaction is seen exactly when the block sees
	// it. Stall bursts start at random and run for a picked number of cycles.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_response(rsp);
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			stall_left = ($urandom_range(0, 5) == 0) ? pick_gap() : 0;
			rsp_stall <= 1'b0;
		end
	end

	// Request side. Called at a rising edge; returns at the edge where the
	// transaction was taken. Valid stays high between back-to-back requests, and is
	// lowered only when an idle gap follows, so it never toggles twice in a step.
	task automatic send_request(input req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		board.note_request(r);
	endtask

	task automatic issue(input logic [2:0] func, input logic [HANDLE_W-1:0] handle,
			input logic [TIME_W-1:0] stamp, input logic level);
		req_t r;
		r.func         = func;
		r.queue_handle = handle;
		r.event_time   = stamp;
		r.edge_level   = level;
		send_request(r);
	endtask

	// Hold the request side off until every outstanding response has come back.
	task automatic drain_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (board.due_responses.size() != 0);
	endtask

	// A random request shaped by the current queue table: mostly events and reads,
	// and the handles of flush, close and read mostly name a live queue, so the
	// queues fill, overflow and drain. The rest carry arbitrary handles.
	function automatic req_t random_request();
		req_t r;
		int roll;
		int q;
		int live [$];
		r.queue_handle = 16'($urandom);
		r.event_time   = $urandom;
		r.edge_level   = 1'($urandom);
		for (q = 0; q < NQ; q++)
			if (board.slot_open[q]) live.push_back(q);
		roll = $urandom_range(0, 99);
		if (live.size() == 0 && roll < 50)
			r.func = FN_OPEN;
		else if (roll < 36)
			r.func = FN_EVENT;
		else if (roll < 66)
			r.func = FN_READ;
		else if (roll < 76)
			r.func = FN_OPEN;
		else if (roll < 84)
			r.func = FN_CLOSE;
		else if (roll < 91)
			r.func = FN_FLUSH;
		else if (roll < 94)
			r.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
		else
			r.func = FN_READ;
		if (roll < 94 && live.size() > 0 && $urandom_range(0, 9) != 0)
			r.queue_handle = board.slot_id[live[$urandom_range(0, live.size() - 1)]];
		return r;
	endfunction

	// Spare codes are ignored by the block, so they do not count toward n.
	task automatic run_random(input int n);
		req_t r;
		int counted;
		counted = 0;
		while (counted < n) begin
			r = random_request();
			send_request(r);
			if (r.func <= FN_READ) counted++;
		end
	endtask

	initial begin
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Event with no queue open stores nothing; handle zero names no queue.
		issue(FN_EVENT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		issue(FN_READ, 16'h0000, 32'h0000_0000, 1'b0);
		// First open gets handle one; a fresh queue reads back empty.
		issue(FN_OPEN, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		issue(FN_READ, 16'd1, 32'h0, 1'b0);
		// Extreme timestamps and both levels go in and come back in order.
		issue(FN_EVENT, 16'h0000, 32'h0000_0000, 1'b0);
		issue(FN_EVENT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		issue(FN_READ, 16'd1, 32'hFFFF_FFFF, 1'b1);
		issue(FN_READ, 16'd1, 32'h0, 1'b0);
		// Flush leaves the queue open but empty.
		issue(FN_EVENT, 16'h0000, 32'h5A5A_A5A5, 1'b1);
		issue(FN_FLUSH, 16'd1, 32'h0, 1'b0);
		issue(FN_READ, 16'd1, 32'h0, 1'b0);
		// After close the handle is unknown to every function.
		issue(FN_CLOSE, 16'd1, 32'h0, 1'b0);
		issue(FN_CLOSE, 16'd1, 32'h0, 1'b0);
		issue(FN_READ, 16'd1, 32'h0, 1'b0);
		// Fill every slot; the extra open fails and leaves the counter alone.
		repeat (NQ + 1) issue(FN_OPEN, 16'($urandom), $urandom, 1'($urandom));
		// A closed middle slot is the lowest free one and is taken again.
		issue(FN_CLOSE, board.slot_id[2], 32'h0, 1'b0);
		issue(FN_OPEN, 16'h0000, 32'h0, 1'b0);
		// Spare function codes.
		for (int c = FN_SPARE_LO; c <= FN_SPARE_HI; c++)
			issue(3'(c), 16'hFFFF, 32'hFFFF_FFFF, 1'b1);

		run_random(250);
		drain_responses();
		steady = 1'b1;
		run_random(150);
		steady = 1'b0;
		run_random(160);
		drain_responses();

		// The two lowest slots are freed and reopened; they start out empty, take the next
		// events, a closed handle is unknown to read, and the first queue is then flushed.
		issue(FN_CLOSE, board.slot_id[0], 32'h0, 1'b0);
		issue(FN_CLOSE, board.slot_id[1], 32'h0, 1'b0);
		issue(FN_OPEN, 16'h0000, 32'h0, 1'b0);
		issue(FN_OPEN, 16'h0000, 32'h0, 1'b0);
		issue(FN_EVENT, 16'h0000, $urandom, 1'b1);
		issue(FN_EVENT, 16'h0000, $urandom, 1'b0);
		issue(FN_READ, board.slot_id[0], 32'h0, 1'b0);
		issue(FN_CLOSE, board.slot_id[1], 32'h0, 1'b0);
		issue(FN_READ, board.slot_id[1], 32'h0, 1'b0);
		issue(FN_FLUSH, board.slot_id[0], 32'h0, 1'b0);
		run_random(70);

		// Let the last responses come home, then watch for strays.
		req_valid <= 1'b0;
		while (board.due_responses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("broadcast_event_queues: match");
		else
			$display("broadcast_event_queues: mismatch");
		$finish;
	end
endmodule
